// ===== sv/gamma_contrast_brightness_curve_macros.svh =====
// Assertion macros used by the checker of the tone curve block.
`ifndef GAMMA_CONTRAST_BRIGHTNESS_CURVE_MACROS_SVH
`define GAMMA_CONTRAST_BRIGHTNESS_CURVE_MACROS_SVH

// Check a property on the rising clock, skip cycles held in reset.
`define GCB_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tone curve check failed");

// Check a property on every rising clock, reset cycles included.
`define GCB_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("tone curve check failed");

`endif

// ===== sv/gcb_pkg.sv =====
`timescale 1ns / 1ps

package gcb_pkg;

    localparam int unsigned DEF_MAX_ENTRIES   = 4096;
    localparam int unsigned DEF_FRACTION_BITS = 16;

    // Q30 mantissa format of the log and exp units
    localparam int unsigned QONE = 30;
    localparam int unsigned Q_W  = QONE + 1;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BRIGHTNESS    = 3'd0,
        REG_CONTRAST      = 3'd1,
        REG_GAMMA_PERCENT = 3'd2,
        REG_MAX_VALUE     = 3'd3,
        REG_TABLE_ENTRIES = 3'd4
    } t_cfg_reg;

    localparam int unsigned PERCENT = 100;

    localparam logic signed [7:0] BRIGHT_LO   = -8'sd100;
    localparam logic signed [7:0] BRIGHT_HI   = 8'sd100;
    localparam logic signed [7:0] CONTRAST_LO = -8'sd100;
    localparam logic signed [7:0] CONTRAST_HI = 8'sd99;
    localparam logic [8:0]        GAMMA_LO    = 9'd10;
    localparam logic [8:0]        GAMMA_HI    = 9'd500;

    localparam logic signed [7:0]  RST_BRIGHTNESS = 8'sd0;
    localparam logic signed [7:0]  RST_CONTRAST   = 8'sd0;
    localparam logic [8:0]         RST_GAMMA      = 9'd100;
    localparam logic [15:0]        RST_MAX_VALUE  = 16'd255;
    localparam logic [12:0]        RST_ENTRIES    = 13'd256;

    // Bitwise integer square root, 64-bit operand.
    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] bit_m;
        rem   = v;
        res   = 64'd0;
        bit_m = 64'd1 << 62;
        for (int s = 0; s < 32; s++) begin
            if (rem >= res + bit_m) begin
                rem = rem - (res + bit_m);
                res = (res >> 1) + bit_m;
            end else begin
                res = res >> 1;
            end
            bit_m = bit_m >> 2;
        end
        return res;
    endfunction

    // Q30 value of 2^(2^-(idx+1)), by repeated square roots of sqrt(2).
    function automatic logic [63:0] root_q30(input int unsigned idx);
        logic [63:0] r;
        r = isqrt64(64'd2 << (2 * QONE));
        for (int unsigned k = 0; k < idx; k++) begin
            r = isqrt64(r << QONE);
        end
        return r;
    endfunction

endpackage

// ===== sv/gcb_log2.sv =====
`timescale 1ns / 1ps

module gcb_log2
    import gcb_pkg::*;
#(
    parameter int unsigned VAL_W = 13,
    parameter int unsigned F     = DEF_FRACTION_BITS,
    parameter int unsigned TAG_W = 1,
    localparam int unsigned PW    = $clog2(VAL_W),
    localparam int unsigned LOG_W = PW + F
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic [VAL_W-1:0] i_val,
    input  logic [TAG_W-1:0] i_tag,
    output logic [LOG_W-1:0] o_log,
    output logic [TAG_W-1:0] o_tag
);

    logic [Q_W-1:0]   r_m   [F+1];
    logic [LOG_W-1:0] r_acc [F+1];
    logic [TAG_W-1:0] r_tag [F+1];

    logic [PW-1:0]  n_pos;
    logic [Q_W-1:0] n_norm;

    // normalize: leading one to bit QONE
    always_comb begin
        n_pos = '0;
        for (int b = 0; b < VAL_W; b++) begin
            if (i_val[b]) begin
                n_pos = PW'(b);
            end
        end
        n_norm = Q_W'(i_val) << (QONE - int'(n_pos));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag[0] <= '0;
        end else if (i_en) begin
            r_tag[0] <= i_tag;
        end
        if (i_en) begin
            r_m[0]   <= n_norm;
            r_acc[0] <= LOG_W'(n_pos);
        end
    end

    // one fraction bit per stage: square, test for two, halve
    for (genvar s = 1; s <= F; s++) begin : g_sq
        logic [2*Q_W-1:0] sq;
        logic [Q_W:0]     sq_sh;
        logic             n_bit;
        logic [Q_W-1:0]   n_m;

        always_comb begin
            sq    = r_m[s-1] * r_m[s-1];
            sq_sh = sq[QONE +: Q_W+1];
            n_bit = sq_sh[Q_W];
            n_m   = n_bit ? sq_sh[Q_W:1] : sq_sh[Q_W-1:0];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag[s] <= '0;
            end else if (i_en) begin
                r_tag[s] <= r_tag[s-1];
            end
            if (i_en) begin
                r_m[s]   <= n_m;
                r_acc[s] <= {r_acc[s-1][LOG_W-2:0], n_bit};
            end
        end
    end

    assign o_log = r_acc[F];
    assign o_tag = r_tag[F];

endmodule

// ===== sv/gcb_div.sv =====
`timescale 1ns / 1ps

module gcb_div #(
    parameter int unsigned NUM_W = 8,
    parameter int unsigned DEN_W = 8,
    parameter int unsigned TAG_W = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    input  logic [TAG_W-1:0] i_tag,
    output logic [NUM_W-1:0] o_quo,
    output logic [TAG_W-1:0] o_tag
);

    logic [DEN_W-1:0] r_rem  [NUM_W];
    logic [NUM_W-1:0] r_work [NUM_W];
    logic [TAG_W-1:0] r_tag  [NUM_W];

    // restoring division, one quotient bit per stage
    for (genvar s = 0; s < NUM_W; s++) begin : g_step
        logic [DEN_W-1:0] rem_in;
        logic [NUM_W-1:0] work_in;
        logic [TAG_W-1:0] tag_in;
        logic [DEN_W:0]   trial;
        logic             ge;
        logic [DEN_W-1:0] n_rem;

        if (s == 0) begin : g_first
            assign rem_in  = '0;
            assign work_in = i_num;
            assign tag_in  = i_tag;
        end else begin : g_next
            assign rem_in  = r_rem[s-1];
            assign work_in = r_work[s-1];
            assign tag_in  = r_tag[s-1];
        end

        always_comb begin
            trial = {rem_in, work_in[NUM_W-1]};
            ge    = trial >= {1'b0, i_den};
            n_rem = ge ? DEN_W'(trial - {1'b0, i_den}) : trial[DEN_W-1:0];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag[s] <= '0;
            end else if (i_en) begin
                r_tag[s] <= tag_in;
            end
            if (i_en) begin
                r_rem[s]  <= n_rem;
                r_work[s] <= {work_in[NUM_W-2:0], ge};
            end
        end
    end

    assign o_quo = r_work[NUM_W-1];
    assign o_tag = r_tag[NUM_W-1];

endmodule

// ===== sv/gamma_contrast_brightness_curve.sv =====
`timescale 1ns / 1ps
// Tone curve generator: one table index in, one curve value out.
// Input stream s_axis: tdata[11:0] holds entry_index, upper bits are zero.
// Output stream m_axis: tdata[15:0] holds curve_value.
// Configuration: i_cfg_we with i_cfg_index (0 brightness, 1 contrast,
// 2 gamma_percent, 3 max_value, 4 table_entries) and i_cfg_wdata; write
// only while no request is in flight.
// Curve: (i/N)^(100/gamma) * M via fixed-point log2 and exp2, then contrast
// about M/2, twice the brightness plus one half, clamp to 0..M.
// Throughput: one request per cycle while m_axis is not stalled.
// Pipeline: the log2 squaring chains, stage A, the bit-per-stage divide by
// gamma, stage B, the exp2 root multiplier chain, stages C to F, the
// bit-per-stage divide by contrast, stage G and the output register.
// Stall: when m_axis_tready is low with a result held, the whole pipeline
// freezes and s_axis_tready drops; nothing is lost or repeated.
// Reset (i_rst_n low, synchronous): valid bits clear, registers return to
// brightness 0, contrast 0, gamma 100, max 255, entries 256.

module gamma_contrast_brightness_curve
    import gcb_pkg::*;
#(
    parameter int unsigned MAX_ENTRIES   = DEF_MAX_ENTRIES,
    parameter int unsigned FRACTION_BITS = DEF_FRACTION_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [15:0]           s_axis_tdata,   // [11:0] entry_index
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [15:0]           m_axis_tdata    // [15:0] curve_value
);

    localparam int unsigned F      = FRACTION_BITS;
    localparam int unsigned VAL_W  = 13;
    localparam int unsigned LG_W   = $clog2(VAL_W) + F;
    localparam int unsigned D1_W   = LG_W + 7;
    localparam int unsigned K_W    = D1_W - F;
    localparam int unsigned SH_W   = K_W + 2;
    localparam int unsigned PROD_W = 16 + Q_W;
    localparam int unsigned TW     = 16 + F;
    localparam int unsigned DIFF_W = TW + 2;
    localparam int unsigned NUM_W  = TW + 10;
    localparam int unsigned D2_W   = TW + 9;
    localparam int unsigned TOT_W  = D2_W + 2;

    typedef struct packed {
        logic         valid;
        logic         zero;
        logic         full;
        logic         big;
        logic [5:0]   sh;
        logic [F-1:0] fr;
    } t_x_tag;

    // ---------------- configuration registers ----------------
    logic [7:0]  r_bright;
    logic [7:0]  r_contrast;
    logic [8:0]  r_gamma;
    logic [15:0] r_max;
    logic [12:0] r_entries;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bright   <= RST_BRIGHTNESS;
            r_contrast <= RST_CONTRAST;
            r_gamma    <= RST_GAMMA;
            r_max      <= RST_MAX_VALUE;
            r_entries  <= RST_ENTRIES;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_BRIGHTNESS:    r_bright   <= i_cfg_wdata[7:0];
                REG_CONTRAST:      r_contrast <= i_cfg_wdata[7:0];
                REG_GAMMA_PERCENT: r_gamma    <= i_cfg_wdata[8:0];
                REG_MAX_VALUE:     r_max      <= i_cfg_wdata[15:0];
                REG_TABLE_ENTRIES: r_entries  <= i_cfg_wdata[12:0];
                default: ;
            endcase
        end
    end

    // Saturate settings; the user must hold them still while requests are in flight, the block does not enforce it.
    logic signed [7:0]  b_cl;
    logic signed [7:0]  c_cl;
    logic [8:0]         g_cl;
    logic [8:0]         half_g;
    logic [15:0]        m_eff;
    logic [VAL_W-1:0]   n_eff;
    logic signed [8:0]  cp_s;
    logic signed [8:0]  den_s;
    logic [7:0]         cp;
    logic [7:0]         den;
    logic signed [18:0] mb;

    always_comb begin
        b_cl = $signed(r_bright);
        if ($signed(r_bright) < BRIGHT_LO) b_cl = BRIGHT_LO;
        if ($signed(r_bright) > BRIGHT_HI) b_cl = BRIGHT_HI;
        c_cl = $signed(r_contrast);
        if ($signed(r_contrast) < CONTRAST_LO) c_cl = CONTRAST_LO;
        if ($signed(r_contrast) > CONTRAST_HI) c_cl = CONTRAST_HI;
        g_cl = r_gamma;
        if (r_gamma < GAMMA_LO) g_cl = GAMMA_LO;
        if (r_gamma > GAMMA_HI) g_cl = GAMMA_HI;
        half_g = g_cl >> 1;
        m_eff  = (r_max == 16'd0) ? 16'd1 : r_max;
        n_eff  = r_entries;
        if (r_entries == '0) n_eff = VAL_W'(1);
        if (32'(r_entries) > MAX_ENTRIES) n_eff = VAL_W'(MAX_ENTRIES);
        // contrast factor (100 + c) / (100 - c)
        cp_s  = 9'(PERCENT) + {c_cl[7], c_cl};
        den_s = 9'(PERCENT) - {c_cl[7], c_cl};
        cp    = cp_s[7:0];
        den   = den_s[7:0];
        // M + 4b + 1, the offset in half counts
        mb = $signed({3'b000, m_eff}) + $signed({{9{b_cl[7]}}, b_cl, 2'b00})
             + 19'sd1;
    end

    // ---------------- flow control ----------------
    logic r_out_valid;
    logic en;
    logic in_fire;

    assign en            = !r_out_valid || m_axis_tready;
    assign s_axis_tready = en;
    assign in_fire       = s_axis_tvalid && en;

    // ---------------- log2 of index and of count ----------------
    logic [LG_W-1:0] lg_i;
    logic [LG_W-1:0] lg_n;
    logic [12:0]     l2_tag_i;
    logic            l2_tag_n;

    gcb_log2 #(.VAL_W(VAL_W), .F(F), .TAG_W(13)) u_log2_idx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_val   ({1'b0, s_axis_tdata[11:0]}),
        .i_tag   ({in_fire, s_axis_tdata[11:0]}),
        .o_log   (lg_i),
        .o_tag   (l2_tag_i)
    );

    gcb_log2 #(.VAL_W(VAL_W), .F(F), .TAG_W(1)) u_log2_cnt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_val   (n_eff),
        .i_tag   (in_fire),
        .o_log   (lg_n),
        .o_tag   (l2_tag_n)
    );

    // ---------------- stage A: scaled log difference ----------------
    logic            r_a_valid;
    logic            r_a_zero;
    logic            r_a_full;
    logic [D1_W-1:0] r_a_dvd;
    logic [LG_W-1:0] a_d;

    assign a_d = lg_n - lg_i;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= l2_tag_i[12] && l2_tag_n;
        end
        if (en) begin
            r_a_zero <= (l2_tag_i[11:0] == 12'd0);
            r_a_full <= ({1'b0, l2_tag_i[11:0]} >= n_eff);
            // round half up: (d*100 + g/2) / g
            r_a_dvd  <= D1_W'(a_d) * D1_W'(PERCENT) + D1_W'(half_g);
        end
    end

    // ---------------- divide by gamma ----------------
    logic [D1_W-1:0] mag;
    logic [2:0]      d1_tag;

    gcb_div #(.NUM_W(D1_W), .DEN_W(9), .TAG_W(3)) u_div_gamma (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_num   (r_a_dvd),
        .i_den   (g_cl),
        .i_tag   ({r_a_valid, r_a_zero, r_a_full}),
        .o_quo   (mag),
        .o_tag   (d1_tag)
    );

    // ---------------- stage B: split exponent ----------------
    t_x_tag          r_b_tag;
    logic [K_W-1:0]  b_k;
    logic [F-1:0]    b_fr;
    logic            b_nz;
    logic [SH_W-1:0] b_sh;

    always_comb begin
        b_k  = mag[D1_W-1:F];
        b_fr = mag[F-1:0];
        b_nz = |b_fr;
        // 2^-mag = 2^-(k+1) * 2^(1-frac) when the fraction is nonzero
        b_sh = SH_W'(QONE - F) + SH_W'(b_k) + SH_W'(b_nz);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_tag.valid <= 1'b0;
        end else if (en) begin
            r_b_tag.valid <= d1_tag[2];
        end
        if (en) begin
            r_b_tag.zero <= d1_tag[1];
            r_b_tag.full <= d1_tag[0];
            r_b_tag.big  <= (b_sh >= SH_W'(64));
            r_b_tag.sh   <= b_sh[5:0];
            r_b_tag.fr   <= b_nz ? F'(~b_fr + 1'b1) : b_fr;
        end
    end

    // ---------------- exp2 of the fraction: one root per stage ----------------
    t_x_tag         r_x_tag [F];
    logic [Q_W-1:0] r_x_acc [F];

    for (genvar s = 0; s < F; s++) begin : g_exp
        localparam logic [Q_W-1:0] ROOT = Q_W'(root_q30(s));
        t_x_tag           tag_in;
        logic [Q_W-1:0]   acc_in;
        logic [2*Q_W-1:0] prod;

        if (s == 0) begin : g_first
            assign tag_in = r_b_tag;
            assign acc_in = Q_W'(1) << QONE;
        end else begin : g_next
            assign tag_in = r_x_tag[s-1];
            assign acc_in = r_x_acc[s-1];
        end

        assign prod = acc_in * ROOT;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_x_tag[s].valid <= 1'b0;
            end else if (en) begin
                r_x_tag[s].valid <= tag_in.valid;
            end
            if (en) begin
                r_x_tag[s].zero <= tag_in.zero;
                r_x_tag[s].full <= tag_in.full;
                r_x_tag[s].big  <= tag_in.big;
                r_x_tag[s].sh   <= tag_in.sh;
                r_x_tag[s].fr   <= tag_in.fr;
                r_x_acc[s]      <= tag_in.fr[F-1-s] ? prod[QONE +: Q_W] : acc_in;
            end
        end
    end

    // ---------------- stage C: scale by max ----------------
    t_x_tag            r_c_tag;
    logic [PROD_W-1:0] r_c_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_tag.valid <= 1'b0;
        end else if (en) begin
            r_c_tag.valid <= r_x_tag[F-1].valid;
        end
        if (en) begin
            r_c_tag.zero <= r_x_tag[F-1].zero;
            r_c_tag.full <= r_x_tag[F-1].full;
            r_c_tag.big  <= r_x_tag[F-1].big;
            r_c_tag.sh   <= r_x_tag[F-1].sh;
            r_c_tag.fr   <= r_x_tag[F-1].fr;
            r_c_prod     <= PROD_W'(m_eff) * PROD_W'(r_x_acc[F-1]);
        end
    end

    // ---------------- stage D: curve term T ----------------
    logic          r_d_valid;
    logic [TW-1:0] r_d_t;
    logic [TW-1:0] d_full;
    logic [TW-1:0] d_t;

    always_comb begin
        d_full = {m_eff, {F{1'b0}}};
        if (r_c_tag.zero) begin
            d_t = '0;
        end else if (r_c_tag.full) begin
            d_t = d_full;
        end else if (r_c_tag.big) begin
            d_t = '0;
        end else begin
            d_t = TW'(r_c_prod >> r_c_tag.sh);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (en) begin
            r_d_valid <= r_c_tag.valid;
        end
        if (en) begin
            r_d_t <= d_t;
        end
    end

    // ---------------- stage E: contrast numerator ----------------
    logic                     r_e_valid;
    logic signed [NUM_W-1:0]  r_e_num;
    logic signed [DIFF_W-1:0] e_diff;
    logic signed [NUM_W-1:0]  e_diff_x;
    logic signed [NUM_W-1:0]  e_cp_x;

    always_comb begin
        e_diff   = $signed({1'b0, r_d_t, 1'b0}) - $signed({2'b00, m_eff, {F{1'b0}}});
        e_diff_x = NUM_W'(e_diff);
        e_cp_x   = $signed({{(NUM_W-8){1'b0}}, cp});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else if (en) begin
            r_e_valid <= r_d_valid;
        end
        if (en) begin
            r_e_num <= e_diff_x * e_cp_x;
        end
    end

    // ---------------- stage F: sign and magnitude for floor ----------------
    logic            r_f_valid;
    logic            r_f_neg;
    logic [D2_W-1:0] r_f_dvd;
    logic            f_neg;
    logic [D2_W-1:0] f_abs;

    always_comb begin
        f_neg = r_e_num[NUM_W-1];
        f_abs = f_neg ? D2_W'(-r_e_num) : D2_W'(r_e_num);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else if (en) begin
            r_f_valid <= r_e_valid;
        end
        if (en) begin
            r_f_neg <= f_neg;
            // round the magnitude up when negative, so the quotient floors
            r_f_dvd <= f_neg ? f_abs + D2_W'(den) - D2_W'(1) : f_abs;
        end
    end

    // ---------------- divide by (100 - contrast) ----------------
    logic [D2_W-1:0] quo;
    logic [1:0]      d2_tag;

    gcb_div #(.NUM_W(D2_W), .DEN_W(8), .TAG_W(2)) u_div_contrast (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_num   (r_f_dvd),
        .i_den   (den),
        .i_tag   ({r_f_valid, r_f_neg}),
        .o_quo   (quo),
        .o_tag   (d2_tag)
    );

    // ---------------- stage G: add offset ----------------
    logic                    r_g_valid;
    logic signed [TOT_W-1:0] r_g_total;
    logic signed [TOT_W-1:0] g_q;
    logic signed [TOT_W-1:0] g_mb;

    always_comb begin
        g_q  = d2_tag[0] ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
        g_mb = TOT_W'(mb);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_valid <= 1'b0;
        end else if (en) begin
            r_g_valid <= d2_tag[1];
        end
        if (en) begin
            r_g_total <= g_q + (g_mb <<< F);
        end
    end

    // ---------------- output register: clamp to 0..M ----------------
    logic [15:0]      r_out_data;
    logic [TOT_W-1:0] o_x;
    logic [15:0]      o_val;

    always_comb begin
        o_x = TOT_W'(r_g_total) >> (F + 1);
        if (r_g_total[TOT_W-1]) begin
            o_val = 16'd0;
        end else if (o_x > TOT_W'(m_eff)) begin
            o_val = m_eff;
        end else begin
            o_val = o_x[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_g_valid;
        end
        if (en) begin
            r_out_data <= o_val;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

// ===== sv/gcb_checker.sv =====
`timescale 1ns / 1ps
`include "gamma_contrast_brightness_curve_macros.svh"

module gcb_checker
    import gcb_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_cfg_we,
    input logic [CFG_IDX_W-1:0]  i_cfg_index,
    input logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic [15:0]           s_axis_tdata,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [15:0]           m_axis_tdata
);

    // shadow of the max value register, seen from the port
    logic [15:0] r_max;
    logic [15:0] max_eff;
    logic        in_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= RST_MAX_VALUE;
        end else if (i_cfg_we && t_cfg_reg'(i_cfg_index) == REG_MAX_VALUE) begin
            r_max <= i_cfg_wdata;
        end
    end

    assign max_eff = (r_max == 16'd0) ? 16'd1 : r_max;
    assign in_fire = s_axis_tvalid && s_axis_tready;

    `GCB_ASSERT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    `GCB_ASSERT(a_out_stable, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    `GCB_ASSERT(a_clamp, i_clk, i_rst_n, m_axis_tvalid |-> m_axis_tdata <= max_eff)
    `GCB_ASSERT(a_ready_empty, i_clk, i_rst_n, !m_axis_tvalid |-> s_axis_tready)
    `GCB_ASSERT_ALWAYS(a_reset_clear, i_clk, !$past(i_rst_n) |-> !m_axis_tvalid && !$past(in_fire))

endmodule

bind gamma_contrast_brightness_curve gcb_checker u_gcb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_cfg_we      (i_cfg_we),
    .i_cfg_index   (i_cfg_index),
    .i_cfg_wdata   (i_cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/gamma_contrast_brightness_curve_checker.sv =====
`timescale 1ns / 1ps

module gamma_contrast_brightness_curve_checker
    import gcb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_req_valid,
    input  logic                  i_req_ready,
    input  logic [15:0]           i_req_data,
    input  logic                  i_res_valid,
    input  logic                  i_res_ready,
    input  logic [15:0]           i_res_data,
    output int                    o_errors,
    output int                    o_pending,
    output int                    o_results
);

    localparam int FB      = 16;
    localparam int Q30     = 30;
    localparam int N_LIMIT = 4096;

    logic signed [7:0] cur_bright;
    logic signed [7:0] cur_contrast;
    logic [8:0]        cur_gamma;
    logic [15:0]       cur_max;
    logic [12:0]       cur_entries;

    logic [15:0] curve_queue[$];
    logic [63:0] exp_roots[FB];

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] b;
        rem = v;
        res = 0;
        b   = 64'd1 << 62;
        while (b > rem) b = b >> 2;
        while (b != 0) begin
            if (rem >= res + b) begin
                rem = rem - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // Truncated log2 with FB fraction bits, by squaring the Q30 mantissa.
    function automatic logic [63:0] log2_q(input logic [63:0] v);
        int          n;
        logic [63:0] m;
        logic [63:0] acc;
        n = 0;
        while ((v >> (n + 1)) != 0) n++;
        m   = v << (Q30 - n);
        acc = n;
        for (int j = 0; j < FB; j++) begin
            m   = (m * m) >> Q30;
            acc = acc << 1;
            if (m >= (64'd2 << Q30)) begin
                acc = acc | 1;
                m   = m >> 1;
            end
        end
        return acc;
    endfunction

    function automatic logic [15:0] curve_at(input logic [11:0] idx);
        longint      b, c, num, den, q, total;
        logic [63:0] g, m, n, i, t, d, mag, k, fr, acc, sh, x;
        b = (cur_bright < BRIGHT_LO) ? BRIGHT_LO :
            (cur_bright > BRIGHT_HI) ? BRIGHT_HI : cur_bright;
        c = (cur_contrast < CONTRAST_LO) ? CONTRAST_LO :
            (cur_contrast > CONTRAST_HI) ? CONTRAST_HI : cur_contrast;
        g = (cur_gamma < GAMMA_LO) ? GAMMA_LO : (cur_gamma > GAMMA_HI) ? GAMMA_HI : cur_gamma;
        m = (cur_max == 0) ? 1 : cur_max;
        n = (cur_entries == 0) ? 1 : cur_entries;
        if (n > N_LIMIT) n = N_LIMIT;
        i = idx;
        if (i == 0) begin
            t = 0;
        end else if (i >= n) begin
            t = m << FB;
        end else begin
            d   = log2_q(n) - log2_q(i);
            mag = (d * 100 + g / 2) / g;
            k   = mag >> FB;
            fr  = mag & ((64'd1 << FB) - 1);
            acc = 64'd1 << Q30;
            if (fr != 0) begin
                k  = k + 1;
                fr = (64'd1 << FB) - fr;
            end
            for (int j = FB - 1; j >= 0; j--)
                if (fr[j]) acc = (acc * exp_roots[FB - 1 - j]) >> Q30;
            sh = Q30 + k - FB;
            t  = (sh >= 64) ? 0 : (m * acc) >> sh;
        end
        num = (100 + c) * (2 * longint'(t) - longint'(m << FB));
        den = 100 - c;
        // round toward minus infinity
        q = (num >= 0) ? num / den : -((-num + den - 1) / den);
        total = q + (longint'(m) + 4 * b + 1) * (longint'(1) << FB);
        x = (total < 0) ? 0 : (64'(total) >> (FB + 1));
        if (x > m) x = m;
        return x[15:0];
    endfunction

    initial begin
        exp_roots[0] = int_sqrt(64'd2 << (2 * Q30));
        for (int j = 1; j < FB; j++) exp_roots[j] = int_sqrt(exp_roots[j - 1] << Q30);
        o_errors  = 0;
        o_results = 0;
    end

    assign o_pending = curve_queue.size();

    always @(posedge i_clk) begin
        logic [15:0] want;
        if (!i_rst_n) begin
            cur_bright   <= RST_BRIGHTNESS;
            cur_contrast <= RST_CONTRAST;
            cur_gamma    <= RST_GAMMA;
            cur_max      <= RST_MAX_VALUE;
            cur_entries  <= RST_ENTRIES;
            curve_queue.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_BRIGHTNESS:    cur_bright   <= i_cfg_wdata[7:0];
                    REG_CONTRAST:      cur_contrast <= i_cfg_wdata[7:0];
                    REG_GAMMA_PERCENT: cur_gamma    <= i_cfg_wdata[8:0];
                    REG_MAX_VALUE:     cur_max      <= i_cfg_wdata;
                    REG_TABLE_ENTRIES: cur_entries  <= i_cfg_wdata[12:0];
                    default: ;
                endcase
            end
            if (i_req_valid && i_req_ready)
                curve_queue.push_back(curve_at(i_req_data[11:0]));
            if (i_res_valid && i_res_ready) begin
                o_results++;
                if (curve_queue.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10)
                        $display("%0t: unexpected result %0d", $realtime, i_res_data);
                end else begin
                    want = curve_queue.pop_front();
                    if (want !== i_res_data) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display("%0t: curve_value expected %0d actual %0d",
                                     $realtime, want, i_res_data);
                    end
                end
            end
        end
    end

endmodule

// ===== tb/gamma_contrast_brightness_curve_tb.sv =====
`timescale 1ns / 1ps

module gamma_contrast_brightness_curve_tb;
    import gcb_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN       = 300;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [15:0]           s_axis_tdata;   // [11:0] entry_index
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [15:0]           m_axis_tdata;   // [15:0] curve_value

    int  mismatch_count;
    int  curves_pending;
    int  curves_seen;
    int  cycle_count;
    int  requests_sent;
    int  phase_count;
    bit  idling_on;
    int  cur_n;   // entry count as the block sees it, for index shaping

    // directed index lists for the reset curve and the widest setup
    logic [11:0] reset_indices[9] = '{12'd0, 12'd1, 12'd2, 12'd128, 12'd255, 12'd256,
                                      12'd4095, 12'hAAA, 12'h555};
    logic [11:0] wide_indices[5]  = '{12'd0, 12'd1, 12'd2, 12'd2048, 12'd4095};

    gamma_contrast_brightness_curve uut (.*);

    gamma_contrast_brightness_curve_checker curve_chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req_valid (s_axis_tvalid),
        .i_req_ready (s_axis_tready),
        .i_req_data  (s_axis_tdata),
        .i_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .i_res_data  (m_axis_tdata),
        .o_errors    (mismatch_count),
        .o_pending   (curves_pending),
        .o_results   (curves_seen)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Abort a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver: stall m_axis in random bursts while idling is enabled.
    initial begin
        m_axis_tready = 1'b1;
        forever begin
            if (idling_on && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end
            @(posedge i_clk);
        end
    end

    // Write all five registers back to back; call only with nothing in flight.
    task automatic load_curve_setup(input logic [7:0] bright, input logic [7:0] contr,
                                    input logic [8:0] gam, input logic [15:0] maxv,
                                    input logic [12:0] entries);
        logic [15:0] vals[5];
        vals = '{16'(bright), 16'(contr), 16'(gam), maxv, 16'(entries)};
        for (int r = 0; r < 5; r++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= r[CFG_IDX_W-1:0];
            i_cfg_wdata <= vals[r];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        cur_n = (entries == 0) ? 1 : (entries > 4096) ? 4096 : entries;
        phase_count++;
    endtask

    // Offer one request, with an optional idle gap before it.
    task automatic send_index(input logic [11:0] idx);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, idx};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        requests_sent++;
    endtask

    // Wait for the pipeline to empty before touching the registers.
    task automatic drain_curves();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (curves_pending != 0) @(posedge i_clk);
    endtask

    // Mostly indices inside the table, with zero, the edge and beyond mixed in.
    function automatic logic [11:0] pick_index();
        case ($urandom_range(0, 9))
            0:       return 12'd0;
            1:       return 12'($urandom_range(0, 4095));
            2:       return 12'(cur_n - 1);
            default: return 12'($urandom_range(0, cur_n - 1));
        endcase
    endfunction

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = REG_BRIGHTNESS;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cycle_count   = 0;
        requests_sent = 0;
        phase_count   = 0;
        idling_on     = 1'b1;
        cur_n         = 256;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset curve: zero, small indices, the table edge, past the edge, all ones.
        foreach (reset_indices[k])
            send_index(reset_indices[k]);
        drain_curves();

        // Extremes: lowest settings, then highest, then saturated out-of-range codes.
        load_curve_setup(-8'sd100, -8'sd100, 9'd10, 16'd1, 13'd1);
        send_index(12'd0);
        send_index(12'd1);
        send_index(12'd4095);
        drain_curves();
        load_curve_setup(8'sd100, 8'sd99, 9'd500, 16'd65535, 13'd4096);
        foreach (wide_indices[k])
            send_index(wide_indices[k]);
        drain_curves();
        load_curve_setup(8'h7F, 8'h80, 9'd0, 16'd0, 13'd0);
        send_index(12'd0);
        send_index(12'd7);
        drain_curves();
        load_curve_setup(8'h80, 8'h7F, 9'h1FF, 16'hFFFF, 13'h1FFF);
        send_index(12'd1);
        send_index(12'd4095);
        send_index(12'd3000);
        drain_curves();

        // Random phases; the last phase runs with no idling on either side.
        for (int p = 0; p < 16; p++) begin
            if (p == 15) idling_on = 1'b0;
            case (p % 4)
                0: load_curve_setup(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                    9'($urandom_range(0, 511)), 16'($urandom),
                                    13'($urandom_range(0, 8191)));
                1: load_curve_setup(8'($urandom_range(0, 200) - 100),
                                    8'($urandom_range(0, 199) - 100),
                                    9'($urandom_range(10, 500)), 16'($urandom_range(1, 65535)),
                                    13'($urandom_range(1, 4096)));
                2: load_curve_setup(8'($urandom_range(0, 40) - 20), 8'($urandom_range(0, 40) - 20),
                                    9'($urandom_range(50, 250)), 16'($urandom_range(200, 4095)),
                                    13'($urandom_range(2, 64)));
                default: load_curve_setup(8'($urandom_range(0, 200) - 100),
                                          8'($urandom_range(0, 199) - 100),
                                          9'($urandom_range(10, 500)), 16'hFFFF, 13'd4096);
            endcase
            repeat (60) send_index(pick_index());
            drain_curves();
        end

        repeat (DRAIN) @(posedge i_clk);
        $display("Sent %0d curve requests over %0d register setups, checked %0d curve values",
                 requests_sent, phase_count, curves_seen);
        $display("Covered saturated register codes, index zero and indices past the table");
        if (mismatch_count == 0 && curves_pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
